>>> hw/rtl/clt_pkg.sv
// Shared constants and types for the command line tokenizer.
// Holds the size limits, the CR/LF codes and the queue entry that runs from the front to the back.
// No dependencies.
package clt_pkg;

   localparam int LINE_BYTES  = 256;
   localparam int MAX_TOKENS  = 8;
   localparam int MAX_ARGS    = 8;
   localparam int HOLD_MAX    = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam int LEN_W  = $clog2(LINE_BYTES + 1);
   localparam int HOLD_W = $clog2(HOLD_MAX + 1);
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef struct packed {
      logic [7:0]          ch;
      logic [HOLD_W-1:0]   hold_cnt;
      logic [HOLD_MAX-1:0] hold_lf;
      logic                feed;
      logic                over;
      logic                last;
      logic                too_long;
   } entry_type;

endpackage

>>> hw/rtl/clt_front.sv
// Front end of the command line tokenizer: takes bytes, tracks line length and holds CR/LF runs.
// Emits one queue entry per byte that the back end must see, or per line end.
// Depends on clt_pkg.
module clt_front
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_byte_in,
   input  logic       req_line_end,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_data
);

   logic [LEN_W-1:0]    len_ff, len_in;
   logic [HOLD_W-1:0]   hold_cnt_ff, hold_cnt_in;
   logic [HOLD_MAX-1:0] hold_lf_ff, hold_lf_in;
   logic                over_ff, over_in;

   logic             accept;
   logic [LEN_W-1:0] len_next;
   logic             active;
   logic             is_crlf;
   logic             hold_ovf;
   logic             hold_add;
   logic             feed;

   assign accept   = req_push && !q_full;
   assign len_next = (len_ff == LEN_W'(LINE_BYTES)) ? len_ff : len_ff + LEN_W'(1);
   assign active   = (len_next != LEN_W'(LINE_BYTES)) && !over_ff;
   assign is_crlf  = (req_byte_in == CH_CR) || (req_byte_in == CH_LF);
   assign hold_ovf = active && is_crlf && (hold_cnt_ff >= HOLD_W'(HOLD_MAX));
   assign hold_add = active && is_crlf && !hold_ovf;
   assign feed     = active && !is_crlf;

   assign q_push = accept && (feed || hold_ovf || req_line_end);

   always_comb begin
      q_data.ch       = req_byte_in;
      q_data.hold_cnt = feed ? hold_cnt_ff : '0;
      q_data.hold_lf  = hold_lf_ff;
      q_data.feed     = feed;
      q_data.over     = hold_ovf;
      q_data.last     = req_line_end;
      q_data.too_long = (len_next == LEN_W'(LINE_BYTES));
   end

   always_comb begin
      len_in      = len_ff;
      hold_cnt_in = hold_cnt_ff;
      hold_lf_in  = hold_lf_ff;
      over_in     = over_ff;
      if (accept) begin
         if (req_line_end) begin
            len_in      = '0;
            hold_cnt_in = '0;
            hold_lf_in  = '0;
            over_in     = 1'b0;
         end else begin
            len_in = len_next;
            if (hold_ovf) begin
               over_in     = 1'b1;
               hold_cnt_in = '0;
               hold_lf_in  = '0;
            end else if (hold_add) begin
               for (int i = 0; i < HOLD_MAX; i++) begin
                  if (hold_cnt_ff == HOLD_W'(i)) begin
                     hold_lf_in[i] = (req_byte_in == CH_LF);
                  end
               end
               hold_cnt_in = hold_cnt_ff + HOLD_W'(1);
            end else if (feed) begin
               hold_cnt_in = '0;
               hold_lf_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         hold_cnt_ff <= '0;
         hold_lf_ff  <= '0;
         over_ff     <= 1'b0;
      end else begin
         len_ff      <= len_in;
         hold_cnt_ff <= hold_cnt_in;
         hold_lf_ff  <= hold_lf_in;
         over_ff     <= over_in;
      end
   end

endmodule

>>> hw/rtl/clt_queue.sv
// Short entry queue between the tokenizer front end and back end.
// Depends on clt_pkg for the entry type and depth.
module clt_queue
   import clt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      nonempty
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Entry pushed into a full queue.");

endmodule

>>> hw/rtl/clt_back.sv
// Back end of the command line tokenizer: walks each queue entry one character per cycle
// when the result register has room, runs the name, key and value parser and drives it.
// Depends on clt_pkg.
module clt_back
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_nonempty,
   input  entry_type  q_data,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_char_out,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_slot,
   output logic [2:0] rsp_status,
   output logic       rsp_final_res
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [3:0] TOK_LAST = 4'(MAX_TOKENS - 1);
   localparam logic [3:0] ARG_LAST = 4'(MAX_ARGS - 1);

   localparam logic [2:0] KIND_NAME  = 3'd0;
   localparam logic [2:0] KIND_KEY   = 3'd1;
   localparam logic [2:0] KIND_VALUE = 3'd2;
   localparam logic [2:0] KIND_PAIR  = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NO_NAME   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_HOLD_OVER = 3'd4;

   typedef enum logic [7:0] {
      PH_NAME    = 8'b0000_0001,
      PH_SKIP    = 8'b0000_0010,
      PH_KEY     = 8'b0000_0100,
      PH_QUOTE   = 8'b0000_1000,
      PH_VALUE   = 8'b0001_0000,
      PH_STOP    = 8'b0010_0000,
      PH_BADNAME = 8'b0100_0000,
      PH_OVER    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [2:0] kind;
      logic [3:0] slot;
      logic [2:0] status;
      logic       final_res;
   } result_type;

   phase_type         phase_ff, phase_in;
   logic              bs_ff, bs_in;
   logic [3:0]        tok_ff, tok_in;
   logic              tok_full_ff, tok_full_in;
   logic [3:0]        arg_ff, arg_in;
   logic              named_ff, named_in;
   entry_type         cur_ff, cur_in;
   logic              cur_vld_ff, cur_vld_in;
   logic [HOLD_W-1:0] pos_ff, pos_in;
   result_type        out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   logic       out_free;
   logic       step;
   logic       in_held;
   logic       held_lf;
   logic [7:0] ch;
   logic       emit;
   logic       consumed;
   logic       done;
   result_type res;
   logic [2:0] status;

   assign out_free = !out_vld_ff || rsp_pop;
   assign step     = cur_vld_ff && out_free;
   assign in_held  = pos_ff < cur_ff.hold_cnt;

   always_comb begin
      held_lf = 1'b0;
      for (int i = 0; i < HOLD_MAX; i++) begin
         if (pos_ff == HOLD_W'(i)) begin
            held_lf = cur_ff.hold_lf[i];
         end
      end
   end

   assign ch = in_held ? (held_lf ? CH_LF : CH_CR) : cur_ff.ch;

   always_comb begin
      if (cur_ff.too_long) begin
         status = ST_TOO_LONG;
      end else if (phase_ff == PH_OVER) begin
         status = ST_HOLD_OVER;
      end else if (phase_ff == PH_NAME && !named_ff) begin
         status = ST_EMPTY;
      end else if (phase_ff == PH_BADNAME) begin
         status = ST_NO_NAME;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      bs_in       = bs_ff;
      tok_in      = tok_ff;
      tok_full_in = tok_full_ff;
      arg_in      = arg_ff;
      named_in    = named_ff;
      cur_in      = cur_ff;
      cur_vld_in  = cur_vld_ff;
      pos_in      = pos_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      consumed    = 1'b1;
      res         = '0;
      if (step) begin
         if (in_held || cur_ff.feed) begin
            case (phase_ff)
               PH_NAME: begin
                  if (ch == CH_SPACE) begin
                     phase_in = named_ff ? PH_SKIP : PH_BADNAME;
                  end else begin
                     named_in = 1'b1;
                     if (ch == CH_UNDER) begin
                        if (!tok_full_ff) begin
                           if (tok_ff != TOK_LAST) begin
                              tok_in = tok_ff + 4'd1;
                           end else begin
                              tok_full_in = 1'b1;
                           end
                        end
                     end else if (!tok_full_ff) begin
                        emit          = 1'b1;
                        res.char_out  = ch;
                        res.kind      = KIND_NAME;
                        res.slot      = tok_ff;
                     end
                  end
               end
               PH_SKIP: begin
                  if (ch == CH_EQUAL) begin
                     phase_in = PH_QUOTE;
                  end else if (ch != CH_SPACE) begin
                     emit         = 1'b1;
                     res.char_out = ch;
                     res.kind     = KIND_KEY;
                     res.slot     = arg_ff;
                     phase_in     = PH_KEY;
                  end
               end
               PH_KEY: begin
                  if (ch == CH_EQUAL) begin
                     phase_in = PH_QUOTE;
                  end else begin
                     emit         = 1'b1;
                     res.char_out = ch;
                     res.kind     = KIND_KEY;
                     res.slot     = arg_ff;
                  end
               end
               PH_QUOTE: begin
                  phase_in = (ch == CH_QUOTE) ? PH_VALUE : PH_STOP;
               end
               PH_VALUE: begin
                  res.slot = arg_ff;
                  if (bs_ff) begin
                     // The escape is resolved first; a plain character is then taken again.
                     bs_in        = 1'b0;
                     emit         = 1'b1;
                     res.kind     = KIND_VALUE;
                     if (ch == CH_QUOTE) begin
                        res.char_out = CH_QUOTE;
                     end else begin
                        res.char_out = CH_BSLASH;
                        consumed     = 1'b0;
                     end
                  end else if (ch == CH_QUOTE) begin
                     emit     = 1'b1;
                     res.kind = KIND_PAIR;
                     if (arg_ff == ARG_LAST) begin
                        phase_in = PH_STOP;
                     end else begin
                        arg_in   = arg_ff + 4'd1;
                        phase_in = PH_SKIP;
                     end
                  end else if (ch == CH_BSLASH) begin
                     bs_in = 1'b1;
                  end else begin
                     emit         = 1'b1;
                     res.char_out = ch;
                     res.kind     = KIND_VALUE;
                  end
               end
               default: begin
               end
            endcase
            if (consumed) begin
               if (in_held) begin
                  pos_in = pos_ff + HOLD_W'(1);
               end else begin
                  cur_in.feed = 1'b0;
               end
            end
         end else if (cur_ff.over) begin
            if (phase_ff inside {PH_NAME, PH_SKIP, PH_KEY, PH_QUOTE, PH_VALUE}) begin
               phase_in = PH_OVER;
            end
            cur_in.over = 1'b0;
         end else if (cur_ff.last) begin
            emit          = 1'b1;
            res.kind      = KIND_END;
            res.status    = status;
            res.slot      = (status == ST_OK) ? tok_ff : 4'd0;
            res.final_res = 1'b1;
            phase_in      = PH_NAME;
            bs_in         = 1'b0;
            tok_in        = '0;
            tok_full_in   = 1'b0;
            arg_in        = '0;
            named_in      = 1'b0;
            cur_in.last   = 1'b0;
         end
      end
      done = (pos_in >= cur_ff.hold_cnt) && !cur_in.feed && !cur_in.over && !cur_in.last;
      if (!cur_vld_ff || (step && done)) begin
         cur_vld_in = q_nonempty;
         q_pop      = q_nonempty;
         cur_in     = q_data;
         pos_in     = '0;
      end
   end

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (emit) begin
         out_in     = res;
         out_vld_in = 1'b1;
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NAME;
         bs_ff       <= 1'b0;
         tok_ff      <= '0;
         tok_full_ff <= 1'b0;
         arg_ff      <= '0;
         named_ff    <= 1'b0;
         cur_vld_ff  <= 1'b0;
         pos_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         bs_ff       <= bs_in;
         tok_ff      <= tok_in;
         tok_full_ff <= tok_full_in;
         arg_ff      <= arg_in;
         named_ff    <= named_in;
         cur_vld_ff  <= cur_vld_in;
         pos_ff      <= pos_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_empty     = !out_vld_ff;
   assign rsp_char_out  = out_ff.char_out;
   assign rsp_kind      = out_ff.kind;
   assign rsp_slot      = out_ff.slot;
   assign rsp_status    = out_ff.status;
   assign rsp_final_res = out_ff.final_res;

   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff.final_res == (out_ff.kind == KIND_END)))
      else $error("Final flag does not match the line end result.");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.kind != KIND_END) |-> (out_ff.status == ST_OK))
      else $error("Nonzero status on a character or pair result.");

   assert property (@(posedge clock) disable iff (reset)
      cur_vld_ff |-> (pos_ff <= cur_ff.hold_cnt))
      else $error("Held byte index ran past the held run.");

endmodule

>>> hw/rtl/command_line_tokenizer_top.sv
// Command line tokenizer. Each accepted request is one byte of a line; the front end takes one
// request per cycle while its four-entry queue has room, and the back end produces at most one
// result per cycle. In the back end a byte is walked once, each held CR/LF that it releases is
// walked before it, and a byte that follows a backslash without being a quote is walked once
// more; a line end and a CR/LF overflow each take a step of their own. A CR/LF byte that is
// held, and any byte past the length limit or after an overflow, takes no back end step.
// The back end waits while its result is not popped. No clearing pass after reset.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
module command_line_tokenizer_top
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_byte_in,
   input  logic       req_line_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_char_out,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_slot,
   output logic [2:0] rsp_status,
   output logic       rsp_final_res
);

   logic      q_push;
   entry_type q_push_data;
   logic      q_full;
   logic      q_pop;
   entry_type q_pop_data;
   logic      q_nonempty;

   assign req_full = q_full;

   clt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_byte_in  (req_byte_in),
      .req_line_end (req_line_end),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   clt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .nonempty  (q_nonempty)
   );

   clt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_nonempty    (q_nonempty),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_char_out  (rsp_char_out),
      .rsp_kind      (rsp_kind),
      .rsp_slot      (rsp_slot),
      .rsp_status    (rsp_status),
      .rsp_final_res (rsp_final_res)
   );

endmodule
